// File: rtl/lmts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmts_pkg
// Shared types, constants and LFSR step functions for the memory test
// sequencer.
// ----------------------------------------------------------------------------
package lmts_pkg;

    localparam int ADDR_BITS     = 24;
    localparam int PATTERN_BITS  = 32;
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;
    localparam int OQ_DEPTH      = 4;

    localparam logic [PATTERN_BITS-1:0] PATTERN_INIT       = 32'hCCAA5533;
    localparam logic [ADDR_BITS-1:0]    SINGLE_SEED_RESET  = 24'hDEC0DE;
    localparam logic [ADDR_BITS-1:0]    FIRST_SEED_RESET   = 24'hABCDEF;
    localparam logic [ADDR_BITS-1:0]    SECOND_SEED_RESET  = 24'hFEDCBA;
    localparam logic [ADDR_BITS-1:0]    ADDR_MASK          = 24'hFFFFFF;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_TEST_MODE   = 3'd0;
    localparam logic [2:0] REG_TARGET_CHIP = 3'd1;
    localparam logic [2:0] REG_SINGLE_SEED = 3'd2;
    localparam logic [2:0] REG_FIRST_SEED  = 3'd3;
    localparam logic [2:0] REG_SECOND_SEED = 3'd4;

    localparam logic [1:0] MODE_SEQUENTIAL = 2'd0;

    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_STEP     = 2'd1,
        OP_READ_RET = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_PASS  = 2'd2,
        KIND_FAIL  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WRITE = 2'd1,
        PH_READ  = 2'd2
    } t_phase;

    typedef struct packed {
        t_opcode                  opcode;
        logic [PATTERN_BITS-1:0]  read_data;
    } t_in_item;

    typedef struct packed {
        t_kind                    kind;
        logic                     chip;
        logic [ADDR_BITS-1:0]     word_address;
        logic [PATTERN_BITS-1:0]  write_data;
        logic                     last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]           test_mode;
        logic                 target_chip;
        logic [ADDR_BITS-1:0] single_walk_seed;
        logic [ADDR_BITS-1:0] first_walk_seed;
        logic [ADDR_BITS-1:0] second_walk_seed;
    } t_cfg;

    // up to two results per processed transaction; push1 only with push0
    typedef struct packed {
        logic      push0;
        logic      push1;
        t_out_item item0;
        t_out_item item1;
    } t_push_req;

    // data LFSR, taps 31,30,29,9, new bit enters at bit 0
    function automatic logic [PATTERN_BITS-1:0] next_pattern(
        input logic [PATTERN_BITS-1:0] p
    );
        logic fb;
        fb = p[31] ^ p[30] ^ p[29] ^ p[9];
        return {p[PATTERN_BITS-2:0], fb};
    endfunction

    // address walk: increment, or LFSR (taps 23,22,21,16) that maps zero to seed
    function automatic logic [ADDR_BITS-1:0] next_offset(
        input logic [ADDR_BITS-1:0] off,
        input logic [ADDR_BITS-1:0] seed,
        input logic                 seq
    );
        logic [ADDR_BITS-1:0] res;
        logic                 fb;
        fb = off[23] ^ off[22] ^ off[21] ^ off[16];
        if (seq) begin
            res = off + 1'b1;
        end else if (off == '0) begin
            res = seed;
        end else begin
            res = {off[ADDR_BITS-2:0], fb};
        end
        return res & ADDR_MASK;
    endfunction

endpackage
`default_nettype wire

// File: rtl/lmts_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmts_cfg_regs
// APB-style configuration registers: test mode, target chip, walk seeds.
// ----------------------------------------------------------------------------
module lmts_cfg_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lmts_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  wire logic [lmts_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic      [lmts_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                     pready,
    output lmts_pkg::t_cfg                           o_cfg
);
    import lmts_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.test_mode        <= MODE_SEQUENTIAL;
            r_cfg.target_chip      <= 1'b0;
            r_cfg.single_walk_seed <= SINGLE_SEED_RESET;
            r_cfg.first_walk_seed  <= FIRST_SEED_RESET;
            r_cfg.second_walk_seed <= SECOND_SEED_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TEST_MODE:   r_cfg.test_mode        <= pwdata[1:0];
                REG_TARGET_CHIP: r_cfg.target_chip      <= pwdata[0];
                REG_SINGLE_SEED: r_cfg.single_walk_seed <= pwdata[ADDR_BITS-1:0];
                REG_FIRST_SEED:  r_cfg.first_walk_seed  <= pwdata[ADDR_BITS-1:0];
                REG_SECOND_SEED: r_cfg.second_walk_seed <= pwdata[ADDR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_TEST_MODE:   prdata = {{(CFG_DATA_BITS-2){1'b0}}, r_cfg.test_mode};
            REG_TARGET_CHIP: prdata = {{(CFG_DATA_BITS-1){1'b0}}, r_cfg.target_chip};
            REG_SINGLE_SEED: prdata = {{(CFG_DATA_BITS-ADDR_BITS){1'b0}},
                                       r_cfg.single_walk_seed};
            REG_FIRST_SEED:  prdata = {{(CFG_DATA_BITS-ADDR_BITS){1'b0}},
                                       r_cfg.first_walk_seed};
            REG_SECOND_SEED: prdata = {{(CFG_DATA_BITS-ADDR_BITS){1'b0}},
                                       r_cfg.second_walk_seed};
            default:         prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/lmts_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmts_engine
// Input register plus the single-pass test state update. Each processed
// transaction pushes zero, one or two results into the output queue.
// ----------------------------------------------------------------------------
module lmts_engine (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire lmts_pkg::t_in_item  i_in_item,
    input  wire lmts_pkg::t_cfg      i_cfg,
    input  wire logic                i_space,
    output lmts_pkg::t_push_req      o_push
);
    import lmts_pkg::*;

    // input stage
    logic     r_in_valid;
    t_in_item r_in;

    // test state
    t_phase                  r_phase,       n_phase;
    logic [ADDR_BITS:0]      r_word_count,  n_word_count;
    logic [ADDR_BITS-1:0]    r_off_first,   n_off_first;
    logic [ADDR_BITS-1:0]    r_off_second,  n_off_second;
    logic [PATTERN_BITS-1:0] r_wr_pat,      n_wr_pat;
    logic [PATTERN_BITS-1:0] r_rd_pat,      n_rd_pat;
    logic [1:0]              r_pending,     n_pending;

    logic                    fire;
    logic                    dual;
    logic                    seq;
    logic                    step_ok;
    t_kind                   step_kind;
    logic [PATTERN_BITS-1:0] step_data;
    logic [ADDR_BITS:0]      wc_inc;
    logic [PATTERN_BITS-1:0] cmp_pat;
    logic                    data_ok;
    logic [1:0]              pend_dec;
    logic                    walk_closed;
    t_push_req               push;

    assign dual       = i_cfg.test_mode[1];
    assign seq        = (i_cfg.test_mode == MODE_SEQUENTIAL);
    assign fire       = r_in_valid && i_space;
    assign o_in_ready = !r_in_valid || fire;
    assign o_push     = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_word_count <= '0;
            r_off_first  <= '0;
            r_off_second <= '0;
            r_wr_pat     <= PATTERN_INIT;
            r_rd_pat     <= PATTERN_INIT;
            r_pending    <= '0;
        end else begin
            r_phase      <= n_phase;
            r_word_count <= n_word_count;
            r_off_first  <= n_off_first;
            r_off_second <= n_off_second;
            r_wr_pat     <= n_wr_pat;
            r_rd_pat     <= n_rd_pat;
            r_pending    <= n_pending;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_word_count = r_word_count;
        n_off_first  = r_off_first;
        n_off_second = r_off_second;
        n_wr_pat     = r_wr_pat;
        n_rd_pat     = r_rd_pat;
        n_pending    = r_pending;
        push         = '0;
        step_ok      = 1'b0;
        step_kind    = KIND_WRITE;
        step_data    = '0;
        wc_inc       = r_word_count + 1'b1;
        cmp_pat      = r_rd_pat;
        data_ok      = 1'b0;
        pend_dec     = r_pending - 1'b1;
        walk_closed  = 1'b0;

        if (fire) begin
            unique case (r_in.opcode)
                OP_START: begin
                    n_phase      = PH_WRITE;
                    n_word_count = '0;
                    n_off_first  = '0;
                    n_off_second = '0;
                    n_pending    = '0;
                    n_rd_pat     = r_wr_pat;
                end

                OP_STEP: begin
                    if (r_phase == PH_WRITE) begin
                        step_data = next_pattern(r_wr_pat);
                        n_wr_pat  = step_data;
                        step_kind = KIND_WRITE;
                        step_ok   = 1'b1;
                    end else if (r_phase == PH_READ && r_pending == '0) begin
                        step_kind = KIND_READ;
                        step_ok   = 1'b1;
                    end

                    if (step_ok) begin
                        push.push0              = 1'b1;
                        push.item0.kind         = step_kind;
                        push.item0.chip         = dual ? 1'b0 : i_cfg.target_chip;
                        push.item0.word_address = r_off_first;
                        push.item0.write_data   = step_data;
                        push.item0.last         = !dual;
                        if (dual) begin
                            push.push1              = 1'b1;
                            push.item1.kind         = step_kind;
                            push.item1.chip         = 1'b1;
                            push.item1.word_address = r_off_second;
                            push.item1.write_data   = step_data;
                            push.item1.last         = 1'b1;
                            n_off_first  = next_offset(r_off_first,
                                                       i_cfg.first_walk_seed, 1'b0);
                            n_off_second = next_offset(r_off_second,
                                                       i_cfg.second_walk_seed, 1'b0);
                        end else begin
                            n_off_first  = next_offset(r_off_first,
                                                       i_cfg.single_walk_seed, seq);
                        end
                        if (step_kind == KIND_READ) begin
                            n_pending = dual ? 2'd2 : 2'd1;
                        end
                        // at 2^ADDR_BITS words: writes turn into reads, reads hold the count
                        if (wc_inc[ADDR_BITS]) begin
                            if (r_phase == PH_WRITE) begin
                                n_phase      = PH_READ;
                                n_word_count = '0;
                                n_off_first  = '0;
                                n_off_second = '0;
                            end else begin
                                n_word_count = {1'b1, {ADDR_BITS{1'b0}}};
                            end
                        end else begin
                            n_word_count = wc_inc;
                        end
                    end
                end

                OP_READ_RET: begin
                    if (r_phase == PH_READ && r_pending != '0) begin
                        // in dual mode the pair shares one pattern word
                        cmp_pat   = (!dual || r_pending >= 2'd2)
                                    ? next_pattern(r_rd_pat) : r_rd_pat;
                        n_rd_pat  = cmp_pat;
                        data_ok   = (r_in.read_data == cmp_pat);
                        n_pending = pend_dec;
                        if (!data_ok || (pend_dec == '0 && r_word_count[ADDR_BITS])) begin
                            if (dual) begin
                                walk_closed = (r_off_first  == i_cfg.first_walk_seed) &&
                                              (r_off_second == i_cfg.second_walk_seed);
                            end else begin
                                walk_closed = seq ||
                                              (r_off_first == i_cfg.single_walk_seed);
                            end
                            push.push0      = 1'b1;
                            push.item0.kind = (data_ok && walk_closed) ? KIND_PASS
                                                                       : KIND_FAIL;
                            push.item0.last = 1'b1;
                            n_phase         = PH_IDLE;
                            n_pending       = '0;
                        end
                    end
                end

                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/lmts_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmts_out_queue
// Result queue: up to two pushes per cycle, one pop per cycle.
// ----------------------------------------------------------------------------
module lmts_out_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire lmts_pkg::t_push_req   i_push,
    output logic                       o_space,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output lmts_pkg::t_out_item        o_out_item
);
    import lmts_pkg::*;

    localparam int PTR_BITS = $clog2(OQ_DEPTH);
    localparam int CNT_BITS = $clog2(OQ_DEPTH + 1);

    t_out_item           r_mem [OQ_DEPTH];
    logic [PTR_BITS-1:0] r_wptr, n_wptr;
    logic [PTR_BITS-1:0] r_rptr, n_rptr;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic [PTR_BITS-1:0] wptr_p1;
    logic                pop;

    assign o_out_valid = (r_count != '0);
    assign o_out_item  = r_mem[r_rptr];
    assign o_space     = (r_count <= CNT_BITS'(OQ_DEPTH - 2));
    assign pop         = o_out_valid && i_out_ready;
    assign wptr_p1     = r_wptr + 1'b1;

    always_comb begin
        n_wptr  = r_wptr + PTR_BITS'(i_push.push0) + PTR_BITS'(i_push.push1);
        n_rptr  = r_rptr + PTR_BITS'(pop);
        n_count = r_count + CNT_BITS'(i_push.push0) + CNT_BITS'(i_push.push1)
                  - CNT_BITS'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wptr] <= i_push.item0;
        end
        if (i_push.push1) begin
            r_mem[wptr_p1] <= i_push.item1;
        end
    end

endmodule
`default_nettype wire

// File: rtl/lfsr_memory_test_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfsr_memory_test_sequencer_core
// LFSR-driven memory self-test sequencer: issues write and read requests,
// checks returned data and reports pass or fail.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_ready / i_in_item) carries commands:
//    start, step (issue next access or access pair), read data return.
//  - Output channel (o_out_valid / i_out_ready / o_out_item) carries write
//    requests, read requests and the final passed / failed verdict; last
//    marks the final result of a command.
//  - APB port sets test mode, target chip and the three walk seeds; write it
//    only while no test command is in flight.
//  - A command is captured in the input register and processed once the
//    result queue has space; its results are written into the queue and
//    presented to the output channel from there.
//  - Throughput: one command per cycle while the result queue has space.
//    Interleaved steps yield two results each, so the one-result-per-cycle
//    output port sets the pace of steps in that mode.
//  - A 4-entry result queue decouples the sides; commands keep flowing while
//    results wait, and processing holds only when fewer than two entries are
//    free. A stalled receiver backs up into o_in_ready after that.
//  - Reset: registers return to their defaults, the test goes idle, both
//    pattern LFSRs reload 0xCCAA5533 and the queue empties.
// ----------------------------------------------------------------------------
module lfsr_memory_test_sequencer_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire lmts_pkg::t_in_item                  i_in_item,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output lmts_pkg::t_out_item                      o_out_item,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lmts_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  wire logic [lmts_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic      [lmts_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                     pready
);
    import lmts_pkg::*;

    t_cfg      cfg;
    t_push_req push;
    logic      space;

    lmts_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // state update: one command per cycle, while the queue has space, into the result queue
    lmts_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_cfg      (cfg),
        .i_space    (space),
        .o_push     (push)
    );

    lmts_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire
